[hw/rtl/sem_pkg.sv]
package sem_pkg;

    // geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = ADDR_W;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // field widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // line buffer word: {older row, previous row}
    localparam int LB_W       = 2 * PIX_W;

    // magnitude arithmetic
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int SUM_W      = 21;
    localparam int ROOT_W     = 8;
    localparam int SAT_LEVEL  = 255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

endpackage

[hw/rtl/sem_ram.sv]
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sem_isqrt.sv]
module sem_isqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sem_pkg::SUM_W-1:0]  operand,
    output logic                       done,
    output logic [sem_pkg::ROOT_W-1:0] root
);

    localparam int RAD_W = 2 * sem_pkg::ROOT_W;
    localparam int REM_W = sem_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(sem_pkg::ROOT_W);

    logic             busy_reg;
    logic             done_reg;
    logic             sat_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [sem_pkg::ROOT_W-1:0] root_reg;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    // one result bit per cycle, restoring method
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (sat_reg || cnt_reg == CNT_W'(sem_pkg::ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sat_reg  <= |operand[sem_pkg::SUM_W-1:RAD_W];
            rad_reg  <= operand[RAD_W-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            if (sat_reg) begin
                root_reg <= sem_pkg::ROOT_W'(sem_pkg::SAT_LEVEL);
            end else begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                if (take) begin
                    rem_reg  <= REM_W'(rem_sh - trial);
                    root_reg <= {root_reg[sem_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= REM_W'(rem_sh);
                    root_reg <= {root_reg[sem_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    // a new operand never lands on a running iteration
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("isqrt started while busy");

endmodule

[hw/rtl/sobel_edge_magnitude.sv]
// channel   | ports                                  | direction | handshake
// ----------+----------------------------------------+-----------+----------------
// pixel in  | s_pixel, s_start_of_frame              | in        | s_valid/s_ready
// result    | m_edge_res, m_edge_valid               | out       | m_valid/m_ready
// config    | cfg_index, cfg_wdata                   | in        | cfg_we, no wait
//
// one item in flight; a not valid or border item goes from fetch straight to done, any
// other through grad, sqr, root and wait (8 root iterations, one bit a cycle, cut short
// when saturated); the next item can be accepted in the cycle after the result is loaded
// the line buffers sit in one ram, read on accept and written back in the cycle after
// a stalled full output register holds the finished item; a new item is taken while
// the previous result still waits; reset (synchronous, active low) clears counters,
// sequencer and config to defaults; line buffer contents stay undefined until written
module sobel_edge_magnitude (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sem_pkg::PIX_W-1:0]      s_pixel,
    input  logic                           s_start_of_frame,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sem_pkg::PIX_W-1:0]      m_edge_res,
    output logic                           m_edge_valid,

    input  logic                           cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_GRAD  = 3'd2;
    localparam logic [2:0] ST_SQR   = 3'd3;
    localparam logic [2:0] ST_ROOT  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam int W_W = sem_pkg::WIDTH_W;
    localparam int H_W = sem_pkg::HEIGHT_W;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [W_W-1:0] width_reg;
    logic [H_W-1:0] height_reg;
    logic [W_W-1:0] w_eff;
    logic [H_W-1:0] h_eff;

    // raster position of the incoming pixel
    logic [sem_pkg::COL_W-1:0] col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0] row_reg, row_next;
    logic [sem_pkg::COL_W-1:0] col_cur;
    logic [sem_pkg::ROW_W-1:0] row_cur;
    logic [W_W-1:0]            col_inc;
    logic [H_W-1:0]            row_t;
    logic                      wrap_col;

    logic accept;
    logic pos_valid;
    logic pos_border;

    // per-item registers
    logic [sem_pkg::PIX_W-1:0]  px_reg;
    logic [sem_pkg::ADDR_W-1:0] addr_reg;
    logic                       calc_reg;
    logic                       valid_reg;

    // 3x3 window, index = row*3 + column, row 0 oldest, column 0 oldest
    logic [sem_pkg::PIX_W-1:0] win_reg [9];

    logic signed [sem_pkg::GRAD_W-1:0] gx_reg, gy_reg;
    logic signed [sem_pkg::GRAD_W-1:0] gx, gy;
    logic [sem_pkg::PIX_W+1:0]         sx_pos, sx_neg, sy_pos, sy_neg;
    logic signed [2*sem_pkg::GRAD_W-1:0] prod_x, prod_y;
    logic [sem_pkg::SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [sem_pkg::SUM_W-1:0]         sum;
    logic [sem_pkg::PIX_W-1:0]         res_reg;

    // line buffer ram
    logic                      ram_we;
    logic [sem_pkg::LB_W-1:0]  ram_wdata;
    logic [sem_pkg::LB_W-1:0]  ram_rdata;
    logic [sem_pkg::PIX_W-1:0] lb_a;   // previous row
    logic [sem_pkg::PIX_W-1:0] lb_b;   // row before that

    // square root unit
    logic                        sq_start;
    logic                        sq_done;
    logic [sem_pkg::ROOT_W-1:0]  sq_root;

    // output register
    logic                      m_valid_reg;
    logic [sem_pkg::PIX_W-1:0] m_edge_res_reg;
    logic                      m_edge_valid_reg;
    logic                      out_load;

    // ---------------------------------------------------------------
    // configuration registers, clamped to the supported frame size
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= W_W'(640);
            height_reg <= H_W'(480);
        end else if (cfg_we) begin
            unique case (cfg_index)
                sem_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[W_W-1:0];
                sem_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (width_reg < W_W'(sem_pkg::MIN_SIZE)) begin
            w_eff = W_W'(sem_pkg::MIN_SIZE);
        end else if (width_reg > W_W'(sem_pkg::MAX_WIDTH)) begin
            w_eff = W_W'(sem_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        priority if (height_reg < H_W'(sem_pkg::MIN_SIZE)) begin
            h_eff = H_W'(sem_pkg::MIN_SIZE);
        end else if (height_reg > H_W'(sem_pkg::MAX_HEIGHT)) begin
            h_eff = H_W'(sem_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // ---------------------------------------------------------------
    // position of the accepted pixel and its classification
    // ---------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // start of frame forces row 0, column 0
    assign col_cur = s_start_of_frame ? '0 : col_reg;
    assign row_cur = s_start_of_frame ? '0 : row_reg;

    // output centre sits one row and one column back; column 0 maps to the
    // last column of the row above, which is border
    assign pos_valid  = (row_cur >= sem_pkg::ROW_W'(2))
                     || (row_cur == sem_pkg::ROW_W'(1) && col_cur != '0);
    assign pos_border = (col_cur == '0) || (col_cur == sem_pkg::COL_W'(1))
                     || ({1'b0, col_cur} >= w_eff)
                     || (row_cur == sem_pkg::ROW_W'(1))
                     || ({1'b0, row_cur} >= h_eff);

    // advance; a size change mid-frame wraps counters at or past the new end
    assign col_inc  = {1'b0, col_cur} + W_W'(1);
    assign wrap_col = (col_inc >= w_eff);
    assign row_t    = {1'b0, row_cur} + H_W'(wrap_col);
    assign col_next = wrap_col ? '0 : col_inc[sem_pkg::COL_W-1:0];
    assign row_next = (row_t >= h_eff) ? '0 : row_t[sem_pkg::ROW_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg    <= s_pixel;
            addr_reg  <= col_cur;
            valid_reg <= pos_valid;
            calc_reg  <= pos_valid && !pos_border;
        end
    end

    // ---------------------------------------------------------------
    // line buffers: read on accept, rotate and write back in fetch
    // ---------------------------------------------------------------
    assign lb_a      = ram_rdata[sem_pkg::PIX_W-1:0];
    assign lb_b      = ram_rdata[sem_pkg::LB_W-1:sem_pkg::PIX_W];
    assign ram_we    = (state_reg == ST_FETCH);
    assign ram_wdata = {lb_a, px_reg};

    sem_ram #(
        .WIDTH (sem_pkg::LB_W),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    // window slides one column for every item, border or not
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= lb_b;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= lb_a;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= px_reg;
        end
    end

    // ---------------------------------------------------------------
    // gradients, squares, root
    // ---------------------------------------------------------------
    assign sx_pos = {2'b00, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b00, win_reg[8]};
    assign sx_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b00, win_reg[6]};
    assign sy_pos = {2'b00, win_reg[6]} + {1'b0, win_reg[7], 1'b0} + {2'b00, win_reg[8]};
    assign sy_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, win_reg[2]};
    assign gx     = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
    assign gy     = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});

    assign prod_x = gx_reg * gx_reg;
    assign prod_y = gy_reg * gy_reg;
    assign sum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_GRAD) begin
            gx_reg <= gx;
            gy_reg <= gy;
        end
        if (state_reg == ST_SQR) begin
            sqx_reg <= prod_x[sem_pkg::SQ_W-1:0];
            sqy_reg <= prod_y[sem_pkg::SQ_W-1:0];
        end
        // invalid and border items give zero
        if (state_reg == ST_FETCH) begin
            res_reg <= '0;
        end else if (state_reg == ST_WAIT && sq_done) begin
            res_reg <= sq_root;
        end
    end

    assign sq_start = (state_reg == ST_ROOT);

    sem_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .operand (sum),
        .done    (sq_done),
        .root    (sq_root)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_FETCH;
            ST_FETCH: state_next = calc_reg ? ST_GRAD : ST_DONE;
            ST_GRAD:  state_next = ST_SQR;
            ST_SQR:   state_next = ST_ROOT;
            ST_ROOT:  state_next = ST_WAIT;
            ST_WAIT:  if (sq_done) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_edge_res_reg   <= res_reg;
            m_edge_valid_reg <= valid_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_res   = m_edge_res_reg;
    assign m_edge_valid = m_edge_valid_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_accept_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_FETCH) && !s_ready)
        else $error("accepted item not followed by line buffer fetch");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ({1'b0, col_reg} < $past(w_eff)))
        else $error("column counter left the row");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_edge_valid_reg) |-> (m_edge_res_reg == '0))
        else $error("not valid result carries a nonzero magnitude");

    a_root_only_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> calc_reg && valid_reg)
        else $error("magnitude computed for a border or invalid item");

endmodule
